>>> design/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// Types, constants and the bytewise CRC-16/CCITT-FALSE update shared by the
// frame encoder modules.
// ----------------------------------------------------------------------------
package cfe_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	typedef struct packed {
		logic       start_req;
		logic [7:0] msg_type;
		logic [7:0] data_len;
		logic [7:0] payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       rejected;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_REJECT,
		KIND_START,
		KIND_DATA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       close_frame;
		logic [7:0] msg_type;
		logic [7:0] data_len;
		logic [7:0] payload_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SYNC2,
		PH_TYPE,
		PH_LEN,
		PH_DATA,
		PH_CRCH,
		PH_CRCL
	} phase_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> design/crc16_frame_encoder.sv
// ----------------------------------------------------------------------------
// crc16_frame_encoder
// Framed packet encoder with CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// A start transaction produces sync, sync, type, length, the first payload
// byte when the length is nonzero, and the two CRC bytes when the frame ends
// (five, six or seven output bytes); a data transaction produces one byte,
// or three when it closes the frame; a refused transaction produces one
// byte with rejected set. Input transactions are taken one per cycle while
// the QUEUE_DEPTH-entry command queue has room; the byte sequencer emits
// one output byte per cycle while the output is not stalled, so in the
// steady state the input is taken as fast as the sequencer drains the
// queue. On an empty block the first output byte passes through the
// command queue and the output register before it is presented. Sync
// bytes are APB registers at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module crc16_frame_encoder #(
	parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cfe_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cfe_pkg::out_item_t             out_item,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cfe_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cfe_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import cfe_pkg::*;

	logic [7:0] sync_first_reg_q;
	logic [7:0] sync_second_reg_q;
	logic       wr_en;
	logic       push_valid;
	logic       push_ready;
	cmd_t       push_data;
	logic       pop_valid;
	logic       pop_ready;
	cmd_t       pop_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_reg_q  <= SYNC_FIRST_RST;
			sync_second_reg_q <= SYNC_SECOND_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_SYNC_FIRST:  sync_first_reg_q  <= pwdata[7:0];
				REG_SYNC_SECOND: sync_second_reg_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_SYNC_FIRST:  prdata[7:0] = sync_first_reg_q;
			REG_SYNC_SECOND: prdata[7:0] = sync_second_reg_q;
			default: begin
			end
		endcase
	end

	cfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready),
		.cmd       (push_data)
	);

	cfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd_ready   (pop_ready),
		.cmd         (pop_data),
		.sync_first  (sync_first_reg_q),
		.sync_second (sync_second_reg_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

>>> design/cfe_front.sv
// ----------------------------------------------------------------------------
// cfe_front
// Accepts input transactions, tracks the open frame and payload count, and
// turns each transaction into a command for the byte sequencer.
// ----------------------------------------------------------------------------
module cfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cfe_pkg::in_item_t in_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output cfe_pkg::cmd_t     cmd
);
	import cfe_pkg::*;

	logic       open_q;
	logic [7:0] left_q;
	logic       open_d;
	logic [7:0] left_d;
	logic       accept;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	always_comb begin
		cmd.msg_type     = in_item.msg_type;
		cmd.data_len     = in_item.data_len;
		cmd.payload_byte = in_item.payload_byte;
		cmd.kind         = KIND_REJECT;
		cmd.close_frame  = 1'b0;
		open_d           = open_q;
		left_d           = left_q;
		if (in_item.start_req) begin
			if (!open_q) begin
				cmd.kind        = KIND_START;
				cmd.close_frame = (in_item.data_len <= 8'd1);
				open_d          = (in_item.data_len > 8'd1);
				left_d          = (in_item.data_len == 8'd0) ? 8'd0
				                  : in_item.data_len - 8'd1;
			end
		end else if (open_q) begin
			cmd.kind        = KIND_DATA;
			cmd.close_frame = (left_q == 8'd1);
			open_d          = (left_q != 8'd1);
			left_d          = left_q - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 8'd0;
		end else if (accept) begin
			open_q <= open_d;
			left_q <= left_d;
		end
	end

endmodule

>>> design/cfe_queue.sv
// ----------------------------------------------------------------------------
// cfe_queue
// Small command FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module cfe_queue #(
	parameter int DEPTH = cfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cfe_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output cfe_pkg::cmd_t pop_data
);
	import cfe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> design/cfe_back.sv
// ----------------------------------------------------------------------------
// cfe_back
// Byte sequencer: expands each command into frame bytes, one per cycle unless
// stalled, keeps the running CRC and drives the registered output channel.
// ----------------------------------------------------------------------------
module cfe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  cfe_pkg::cmd_t      cmd,
	input  logic [7:0]         sync_first,
	input  logic [7:0]         sync_second,
	output logic               out_valid,
	input  logic               out_ready,
	output cfe_pkg::out_item_t out_item
);
	import cfe_pkg::*;

	phase_t      phase_q;
	phase_t      phase_d;
	logic [15:0] crc_q;
	logic [15:0] crc_d;
	logic        out_valid_q;
	out_item_t   out_item_q;
	out_item_t   item_d;
	logic        emit;
	logic        last;

	assign emit      = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_ready = emit && last;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		item_d    = '0;
		phase_d   = PH_FIRST;
		crc_d     = crc_q;
		last      = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				case (cmd.kind)
					KIND_START: begin
						item_d.out_byte = sync_first;
						crc_d           = CRC_INIT;
						phase_d         = PH_SYNC2;
					end
					KIND_DATA: begin
						item_d.out_byte = cmd.payload_byte;
						crc_d           = crc_feed(crc_q, cmd.payload_byte);
						if (cmd.close_frame) begin
							phase_d = PH_CRCH;
						end else begin
							last = 1'b1;
						end
					end
					default: begin
						item_d.rejected = 1'b1;
						last            = 1'b1;
					end
				endcase
			end
			PH_SYNC2: begin
				item_d.out_byte = sync_second;
				phase_d         = PH_TYPE;
			end
			PH_TYPE: begin
				item_d.out_byte = cmd.msg_type;
				crc_d           = crc_feed(crc_q, cmd.msg_type);
				phase_d         = PH_LEN;
			end
			PH_LEN: begin
				item_d.out_byte = cmd.data_len;
				crc_d           = crc_feed(crc_q, cmd.data_len);
				phase_d         = (cmd.data_len == 8'd0) ? PH_CRCH : PH_DATA;
			end
			PH_DATA: begin
				item_d.out_byte = cmd.payload_byte;
				crc_d           = crc_feed(crc_q, cmd.payload_byte);
				if (cmd.close_frame) begin
					phase_d = PH_CRCH;
				end else begin
					last = 1'b1;
				end
			end
			PH_CRCH: begin
				item_d.out_byte = crc_q[15:8];
				phase_d         = PH_CRCL;
			end
			PH_CRCL: begin
				item_d.out_byte  = crc_q[7:0];
				item_d.frame_end = 1'b1;
				crc_d            = CRC_INIT;
				last             = 1'b1;
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			phase_q     <= phase_d;
			crc_q       <= crc_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q <= item_d;
		end
	end

endmodule

>>> design/cfe_checker.sv
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks for the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cfe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input cfe_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input cfe_pkg::out_item_t out_item,
	input logic               pready
);
	import cfe_pkg::*;

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output transaction changed while stalled");

	a_rej_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rejected |-> out_item.out_byte == 8'h00 && !out_item.frame_end)
		else $error("rejected transaction carries data");

	// the low CRC byte is never the first byte after a frame end
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.frame_end |=> !(out_valid && out_item.frame_end))
		else $error("two frame ends in a row");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind crc16_frame_encoder cfe_checker u_cfe_checker (.*);

>>> tb/crc16_frame_checker.sv
// ----------------------------------------------------------------------------
// crc16_frame_checker
// Watches the input, output and APB channels of crc16_frame_encoder. It
// predicts every output byte of each frame (sync bytes, header, payload,
// CRC-16/CCITT-FALSE trailer, rejects) and compares in order.
// ----------------------------------------------------------------------------
module crc16_frame_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  cfe_pkg::in_item_t              in_item,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  cfe_pkg::out_item_t             out_item,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [cfe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cfe_pkg::APB_DATA_W-1:0] pwdata,
	output int                             fail_count,
	output int                             backlog
);
	import cfe_pkg::*;

	out_item_t   frame_bytes_q[$];
	out_item_t   got;
	out_item_t   want;
	logic [15:0] crc_acc;
	logic [7:0]  left_cnt;
	logic        open_f;
	logic [7:0]  sync_a;
	logic [7:0]  sync_b;
	int          errs = 0;

	initial begin
		fail_count = 0;
		backlog    = 0;
	end

	// MSB-first bitwise CRC update
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	task automatic emit(input logic [7:0] b, input logic e, input logic r);
		out_item_t o;
		o.out_byte  = b;
		o.frame_end = e;
		o.rejected  = r;
		frame_bytes_q.push_back(o);
	endtask

	task automatic close_out();
		emit(crc_acc[15:8], 1'b0, 1'b0);
		emit(crc_acc[7:0], 1'b1, 1'b0);
		crc_acc  = CRC_INIT;
		left_cnt = 8'd0;
		open_f   = 1'b0;
	endtask

	task automatic take_byte(input logic [7:0] b);
		emit(b, 1'b0, 1'b0);
		crc_acc  = crc_byte(crc_acc, b);
		left_cnt = left_cnt - 8'd1;
		if (left_cnt == 8'd0) begin
			close_out();
		end else begin
			open_f = 1'b1;
		end
	endtask

	task automatic predict_frame(input in_item_t it);
		if (it.start_req) begin
			if (open_f) begin
				emit(8'h00, 1'b0, 1'b1);
			end else begin
				emit(sync_a, 1'b0, 1'b0);
				emit(sync_b, 1'b0, 1'b0);
				emit(it.msg_type, 1'b0, 1'b0);
				emit(it.data_len, 1'b0, 1'b0);
				crc_acc  = crc_byte(crc_byte(CRC_INIT, it.msg_type), it.data_len);
				left_cnt = it.data_len;
				if (it.data_len == 8'd0) begin
					close_out();
				end else begin
					take_byte(it.payload_byte);
				end
			end
		end else if (!open_f) begin
			emit(8'h00, 1'b0, 1'b1);
		end else begin
			take_byte(it.payload_byte);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			frame_bytes_q.delete();
			crc_acc  = CRC_INIT;
			left_cnt = 8'd0;
			open_f   = 1'b0;
			sync_a   = SYNC_FIRST_RST;
			sync_b   = SYNC_SECOND_RST;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SYNC_FIRST) begin
					sync_a = pwdata[7:0];
				end else begin
					sync_b = pwdata[7:0];
				end
			end
			if (in_valid && in_ready) begin
				predict_frame(in_item);
			end
			if (out_valid && out_ready) begin
				got = out_item;
				if (frame_bytes_q.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("checker: unexpected byte %h end %b rej %b",
							got.out_byte, got.frame_end, got.rejected);
					end
				end else begin
					want = frame_bytes_q.pop_front();
					if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
							got.rejected !== want.rejected) begin
						errs++;
						if (errs <= 10) begin
							$display("checker: byte %h/%h end %b/%b rej %b/%b (exp/got)",
								want.out_byte, got.out_byte, want.frame_end, got.frame_end,
								want.rejected, got.rejected);
						end
					end
				end
			end
		end
		fail_count <= errs;
		backlog    <= frame_bytes_q.size();
	end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for crc16_frame_encoder. Directed frames and rejects, then three
// random phases with different sync settings and back-pressure patterns,
// including one long output stall. Checking is done by crc16_frame_checker.
// ----------------------------------------------------------------------------
module tb;
	import cfe_pkg::*;

	localparam int LIMIT = 400000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int   fail_count;
	int   backlog;
	int   cycles     = 0;
	int   send_idle  = 30;
	int   recv_idle  = 74;
	logic hold_go    = 1'b0;
	logic hold_done  = 1'b0;
	int   hold_left  = 0;
	logic gen_open   = 1'b0;
	int   gen_left   = 0;

	crc16_frame_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	crc16_frame_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .backlog(backlog)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= 150;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic in_item_t mk_item(input logic s, input logic [7:0] t,
			input logic [7:0] l, input logic [7:0] b);
		in_item_t it;
		it.start_req    = s;
		it.msg_type     = t;
		it.data_len     = l;
		it.payload_byte = b;
		return it;
	endfunction

	task automatic push_item(input in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// track frame state for stimulus shaping
		if (it.start_req) begin
			if (!gen_open && it.data_len != 8'd0) begin
				gen_left = it.data_len - 1;
				gen_open = (gen_left != 0);
			end
		end else if (gen_open) begin
			gen_left--;
			gen_open = (gen_left != 0);
		end
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic settle();
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int n);
		in_item_t it;
		logic [7:0] len;
		repeat (n) begin
			it = mk_item(1'($urandom_range(1)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
			if ($urandom_range(99) >= 8) begin
				if (gen_open) begin
					it.start_req = 1'b0;
				end else begin
					len = ($urandom_range(9) == 0) ? 8'($urandom_range(40, 9))
						: 8'($urandom_range(8));
					it.start_req = 1'b1;
					it.data_len  = len;
				end
			end else begin
				// broken sequence: start while open or data while closed
				it.start_req = gen_open;
			end
			push_item(it);
		end
		while (gen_open) begin
			push_item(mk_item(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255))));
		end
		in_valid <= 1'b0;
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects, zero/one-byte frames, field extremes
		push_item(mk_item(1'b0, 8'hFF, 8'hFF, 8'hFF));
		push_item(mk_item(1'b1, 8'h00, 8'h00, 8'hFF));
		push_item(mk_item(1'b1, 8'hFF, 8'h01, 8'h00));
		push_item(mk_item(1'b1, 8'h5A, 8'h03, 8'h80));
		push_item(mk_item(1'b1, 8'hFF, 8'hFF, 8'hFF));
		push_item(mk_item(1'b0, 8'h00, 8'h00, 8'h01));
		push_item(mk_item(1'b0, 8'hFF, 8'hFF, 8'hFF));
		push_item(mk_item(1'b1, 8'hA5, 8'h02, 8'h7F));
		push_item(mk_item(1'b0, 8'h00, 8'h00, 8'hFE));
		push_item(mk_item(1'b0, 8'h00, 8'h00, 8'h00));
		push_item(mk_item(1'b1, 8'h80, 8'h00, 8'h00));
		push_item(mk_item(1'b1, 8'h01, 8'h01, 8'hFF));
		in_valid <= 1'b0;
		settle();

		write_reg(REG_SYNC_FIRST, 32'hFFFF_FF00);
		write_reg(REG_SYNC_SECOND, 32'h1234_56FF);
		run_phase(65);

		send_idle = 74;
		recv_idle = 30;
		write_reg(REG_SYNC_FIRST, {16'($urandom_range(16'hFFFF)), 16'h00FF});
		write_reg(REG_SYNC_SECOND, {16'($urandom_range(16'hFFFF)), 16'hFF00});
		run_phase(65);

		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_SYNC_FIRST, $urandom);
		write_reg(REG_SYNC_SECOND, $urandom);
		hold_go = 1'b1;
		run_phase(65);

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
